// ===== hw/rtl/psd_pkg.sv =====
`timescale 1ns / 1ps
package psd_pkg;
  localparam int HistDepth = 32;
  localparam int CoordBits = 20;
  localparam int IdxW = $clog2(HistDepth);
  localparam int CntW = $clog2(HistDepth + 1);
  localparam int DiffW = CoordBits + 1;
  localparam int SqW = 2 * DiffW + 1;
  localparam int RootW = (SqW + 1) / 2;
  localparam int DistW = RootW + IdxW + 1;
  localparam logic [DistW-1:0] MinDiag = DistW'(1600);
  localparam int Tol = 16;
  localparam int EntW = 2 * CoordBits + 32;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_SENS = 1'b1;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic             start;
    logic [SqW-1:0]   radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;
endpackage

// ===== hw/rtl/psd_sqrt.sv =====
`timescale 1ns / 1ps
module psd_sqrt import psd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);
  localparam int RemW = RootW + 2;
  localparam int StepW = $clog2(RootW + 1);

  logic [SqW:0]       rad_r, rad_nxt;
  logic [RemW-1:0]    rem_r, rem_nxt;
  logic [RootW-1:0]   root_r, root_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [RemW-1:0]    trial;
  logic [RemW-1:0]    shifted;

  // one root bit per cycle, restoring method
  always_comb begin
    shifted  = {rem_r[RemW-3:0], rad_r[SqW:SqW-1]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rad_nxt  = {1'b0, req.radicand};
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = StepW'(RootW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SqW-2:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[RootW-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;
endmodule

// ===== hw/rtl/psd_hist_mem.sv =====
`timescale 1ns / 1ps
module psd_hist_mem import psd_pkg::*; (
  input  logic            clk,
  input  logic            we,
  input  logic [IdxW-1:0] waddr,
  input  logic [EntW-1:0] wdata,
  input  logic [IdxW-1:0] raddr,
  output logic [EntW-1:0] rdata
);
  logic [EntW-1:0] mem [HistDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/pointer_shake_detector.sv =====
`timescale 1ns / 1ps
// Timing: a clear is answered from idle; a motion sample's time grows with the stored points
// after the update and with the pruned points, set by the shared bit-serial square root (one
// root per segment, plus one for the diagonal) and the one-port history read loop.
// A replaced last point skips the walk and finishes after pruning.
// Throughput: one transaction in flight; the next is taken once the result has been accepted.
// History is a circular buffer in RAM (head and count registers), no clearing pass.
// Reset: synchronous active-low; count empty, window_ms 1000, sensitivity 1024.
module pointer_shake_detector import psd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,  // command[0], pos_x[20:1], pos_y[40:21], time_ms[72:41]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata, // shake_detected[0]
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_PRUNE_RD, S_PRUNE_CHK, S_DIR_RD1, S_DIR_RD2, S_DIR_CHK,
    S_APPEND, S_WALK_RD, S_WALK_GO, S_WALK_WAIT, S_DIAG, S_DIAG_WAIT, S_DONE
  } state_t;

  state_t state_r;
  logic [15:0] window_r, sens_r;
  logic [IdxW-1:0] head_r;
  logic [CntW-1:0] count_r;
  logic [IdxW-1:0] idx_r;
  logic signed [CoordBits-1:0] px_r, py_r, prx_r, pry_r;
  logic signed [CoordBits-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic [31:0] t_r;
  logic [DistW-1:0] dist_r;
  logic out_valid_r, shake_r;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata, rdata;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  logic signed [CoordBits-1:0] rx, ry;
  logic [31:0] rt;
  assign rx = rdata[CoordBits-1:0];
  assign ry = rdata[2*CoordBits-1:CoordBits];
  assign rt = rdata[EntW-1:2*CoordBits];

  psd_hist_mem u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  psd_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  function automatic logic same_dir(input logic signed [DiffW-1:0] a,
                                    input logic signed [DiffW-1:0] b);
    same_dir = (a >= -DiffW'(Tol) && b >= -DiffW'(Tol)) ||
               (a <= DiffW'(Tol) && b <= DiffW'(Tol));
  endfunction

  function automatic logic [SqW-1:0] hyp_sq(input logic signed [DiffW-1:0] a,
                                            input logic signed [DiffW-1:0] b);
    logic [DiffW-1:0] ma, mb;
    ma = a[DiffW-1] ? DiffW'(-a) : a;
    mb = b[DiffW-1] ? DiffW'(-b) : b;
    hyp_sq = SqW'(ma) * SqW'(ma) + SqW'(mb) * SqW'(mb);
  endfunction

  // in S_APPEND rdata holds the last point, prx_r/pry_r the one before it
  logic signed [DiffW-1:0] dx1, dx2, dy1, dy2;
  logic [31:0] age;
  logic [CntW-1:0] last_off;
  logic replace;
  assign age = t_r - rt;
  assign dx1 = DiffW'(rx) - DiffW'(prx_r);
  assign dy1 = DiffW'(ry) - DiffW'(pry_r);
  assign dx2 = DiffW'(px_r) - DiffW'(rx);
  assign dy2 = DiffW'(py_r) - DiffW'(ry);
  assign last_off = count_r - 1'b1;
  assign replace = (count_r >= CntW'(2)) && same_dir(dx1, dx2) && same_dir(dy1, dy2);

  logic [IdxW-1:0] cnt_idx;
  assign cnt_idx = count_r[IdxW-1:0];

  logic [15+DistW:0] rhs;
  assign rhs = sens_r * sq_rsp.root;

  always_comb begin
    raddr = head_r + idx_r;
    we = 1'b0;
    waddr = head_r + cnt_idx;
    wdata = {t_r, py_r, px_r};
    sq_req.start = 1'b0;
    sq_req.radicand = hyp_sq(DiffW'(rx) - DiffW'(prx_r), DiffW'(ry) - DiffW'(pry_r));
    if (state_r == S_APPEND) begin
      we = 1'b1;
      if (replace) waddr = head_r + last_off[IdxW-1:0];
    end
    if (state_r == S_WALK_GO) sq_req.start = (idx_r != '0);
    if (state_r == S_DIAG) begin
      sq_req.start = 1'b1;
      sq_req.radicand = hyp_sq(DiffW'(maxx_r) - DiffW'(minx_r),
                               DiffW'(maxy_r) - DiffW'(miny_r));
    end
  end

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'b0, shake_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      window_r <= 16'd1000;
      sens_r <= 16'd1024;
      head_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
      shake_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW: window_r <= cfg_data;
          CFG_SENS:   sens_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            px_r <= in_tdata[CoordBits:1];
            py_r <= in_tdata[2*CoordBits:CoordBits+1];
            t_r <= in_tdata[2*CoordBits+32:2*CoordBits+1];
            idx_r <= '0;
            if (in_tdata[0] == CMD_CLEAR) begin
              count_r <= '0;
              shake_r <= 1'b0;
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_PRUNE_RD;
            end
          end
        end
        S_PRUNE_RD: begin
          state_r <= (count_r == '0) ? S_DIR_RD1 : S_PRUNE_CHK;
        end
        S_PRUNE_CHK: begin
          if (age >= 32'(window_r)) begin
            head_r <= head_r + 1'b1;
            count_r <= count_r - 1'b1;
            state_r <= S_PRUNE_RD;
          end else begin
            state_r <= S_DIR_RD1;
          end
        end
        S_DIR_RD1: begin
          idx_r <= IdxW'(count_r - CntW'(2));
          state_r <= (count_r >= CntW'(2)) ? S_DIR_RD2 : S_DIR_CHK;
        end
        S_DIR_RD2: begin
          idx_r <= last_off[IdxW-1:0];
          state_r <= S_DIR_CHK;
        end
        S_DIR_CHK: begin
          // rdata holds the previous point; the last point arrives next cycle
          prx_r <= rx;
          pry_r <= ry;
          state_r <= S_APPEND;
        end
        S_APPEND: begin
          if (replace) begin
            shake_r <= 1'b0;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            if (count_r == CntW'(HistDepth)) begin
              head_r <= head_r + 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
            end
            idx_r <= '0;
            dist_r <= '0;
            state_r <= S_WALK_RD;
          end
        end
        S_WALK_RD: state_r <= S_WALK_GO;
        S_WALK_GO: begin
          if (idx_r == '0) begin
            minx_r <= rx; maxx_r <= rx; miny_r <= ry; maxy_r <= ry;
          end else begin
            if (rx < minx_r) minx_r <= rx;
            if (rx > maxx_r) maxx_r <= rx;
            if (ry < miny_r) miny_r <= ry;
            if (ry > maxy_r) maxy_r <= ry;
          end
          prx_r <= rx;
          pry_r <= ry;
          state_r <= (idx_r == '0) ? S_WALK_WAIT : S_WALK_WAIT;
        end
        S_WALK_WAIT: begin
          if (idx_r == '0 || sq_rsp.done) begin
            if (idx_r != '0) dist_r <= dist_r + DistW'(sq_rsp.root);
            if (CntW'(idx_r) == last_off) begin
              state_r <= S_DIAG;
            end else begin
              idx_r <= idx_r + 1'b1;
              state_r <= S_WALK_RD;
            end
          end
        end
        S_DIAG: state_r <= S_DIAG_WAIT;
        S_DIAG_WAIT: begin
          if (sq_rsp.done) begin
            shake_r <= 1'b0;
            if (DistW'(sq_rsp.root) >= MinDiag &&
                (DistW+16)'({dist_r, 8'b0}) > rhs) begin
              shake_r <= 1'b1;
              count_r <= '0;
            end
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(HistDepth)) else $error("history count overflow");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("accept while busy");
  a_shake_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && shake_r |-> count_r == '0) else $error("shake kept history");
endmodule
